// ----- rtl/lruac_pkg.sv -----
package lruac_pkg;

  localparam int SETS      = 256;
  localparam int SET_BITS  = $clog2(SETS);
  localparam int MAX_WAYS  = 16;
  localparam int WAY_BITS  = $clog2(MAX_WAYS);
  localparam int AGE_WIDTH = 16;
  localparam int ROW_WIDTH = MAX_WAYS * AGE_WIDTH;
  localparam int CFG_BITS  = 5;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CMD_ACCESS = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [CFG_BITS-1:0] WAYS_RESET = CFG_BITS'(MAX_WAYS);

  typedef struct packed {
    logic                kind;
    logic [SET_BITS-1:0] set_addr;
    logic [MAX_WAYS-1:0] hit_mask;
    logic [MAX_WAYS-1:0] use_mask;
  } req_t;

endpackage

// ----- rtl/lruac_ram.sv -----
module lruac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/lruac_front.sv -----
module lruac_front import lruac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  input  logic                in_tvalid,
  input  logic [15:0]         in_tdata,
  input  logic [0:0]          in_tuser,
  input  logic                q_full,
  output logic                push,
  output req_t                push_req
);

  logic [CFG_BITS-1:0] ways_in_use_r;
  logic [CFG_BITS-1:0] ways_eff;
  logic [WAY_BITS-1:0] acc_way;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_in_use_r <= WAYS_RESET;
    end else if (cfg_wr_en) begin
      ways_in_use_r <= cfg_wr_data;
    end
  end

  always_comb begin
    ways_eff = ways_in_use_r;
    if (ways_in_use_r == '0) begin
      ways_eff = CFG_BITS'(1);
    end else if (ways_in_use_r > CFG_BITS'(MAX_WAYS)) begin
      ways_eff = CFG_BITS'(MAX_WAYS);
    end
  end

  assign acc_way = in_tdata[SET_BITS +: WAY_BITS];

  always_comb begin
    push_req.kind     = in_tuser[0];
    push_req.set_addr = in_tdata[SET_BITS-1:0];
    for (int i = 0; i < MAX_WAYS; i++) begin
      push_req.use_mask[i] = CFG_BITS'(i) < ways_eff;
      push_req.hit_mask[i] = (in_tuser[0] == CMD_ACCESS) && (acc_way == WAY_BITS'(i));
    end
  end

  assign push = in_tvalid && !q_full;

endmodule

// ----- rtl/lruac_queue.sv -----
module lruac_queue import lruac_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_req,
  input  logic pop,
  output req_t pop_req,
  output logic full,
  output logic empty
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  req_t                 slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_r;
  logic [PTR_BITS-1:0]  rd_ptr_r;
  logic [CNT_BITS-1:0]  count_r;
  logic [CNT_BITS-1:0]  count_nxt;

  assign full    = count_r == CNT_BITS'(QUEUE_DEPTH);
  assign empty   = count_r == '0;
  assign pop_req = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ----- rtl/lruac_back.sv -----
module lruac_back import lruac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  req_t                q_req,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [WAY_BITS-1:0] victim_way
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam int   LEVELS = WAY_BITS;

  logic                 state_r;
  logic                 state_nxt;
  req_t                 cur_r;
  logic [SETS-1:0]      row_vld_r;
  logic [ROW_WIDTH-1:0] ram_rdata;
  logic [ROW_WIDTH-1:0] row_cur;
  logic [ROW_WIDTH-1:0] row_new;
  logic                 ram_we;
  logic                 out_valid_r;
  logic [WAY_BITS-1:0]  victim_r;
  logic                 out_free;
  logic                 load_out;

  logic [AGE_WIDTH-1:0] t_age [LEVELS+1][MAX_WAYS];
  logic [WAY_BITS-1:0]  t_idx [LEVELS+1][MAX_WAYS];
  logic                 t_vld [LEVELS+1][MAX_WAYS];
  logic                 pick_hi;

  lruac_ram #(
    .WIDTH (ROW_WIDTH),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_r.set_addr),
    .wdata (row_new),
    .re    (pop),
    .raddr (q_req.set_addr),
    .rdata (ram_rdata)
  );

  assign row_cur  = row_vld_r[cur_r.set_addr] ? ram_rdata : '0;
  assign out_free = !out_valid_r || out_tready;
  assign pop      = (state_r == S_IDLE) && !q_empty;
  assign ram_we   = (state_r == S_EXEC) && (cur_r.kind == CMD_ACCESS);
  assign load_out = (state_r == S_EXEC) && (cur_r.kind == CMD_QUERY) && out_free;

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      row_new[i*AGE_WIDTH +: AGE_WIDTH] = row_cur[i*AGE_WIDTH +: AGE_WIDTH];
      if (cur_r.use_mask[i]) begin
        if (cur_r.hit_mask[i]) begin
          row_new[i*AGE_WIDTH +: AGE_WIDTH] = '0;
        end else if (row_cur[i*AGE_WIDTH +: AGE_WIDTH] != '1) begin
          row_new[i*AGE_WIDTH +: AGE_WIDTH] =
            row_cur[i*AGE_WIDTH +: AGE_WIDTH] + AGE_WIDTH'(1);
        end
      end
    end
  end

  // Pairwise maximum tree; the upper half wins ties so the highest way is chosen.
  always_comb begin
    pick_hi = 1'b0;
    for (int k = 0; k <= LEVELS; k++) begin
      for (int j = 0; j < MAX_WAYS; j++) begin
        t_age[k][j] = '0;
        t_idx[k][j] = '0;
        t_vld[k][j] = 1'b0;
      end
    end
    for (int j = 0; j < MAX_WAYS; j++) begin
      t_age[0][j] = row_cur[j*AGE_WIDTH +: AGE_WIDTH];
      t_idx[0][j] = WAY_BITS'(j);
      t_vld[0][j] = cur_r.use_mask[j] || (j == 0);
    end
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < (MAX_WAYS >> (k + 1)); j++) begin
        pick_hi = t_vld[k][2*j+1] &&
                  (!t_vld[k][2*j] || (t_age[k][2*j+1] >= t_age[k][2*j]));
        t_age[k+1][j] = pick_hi ? t_age[k][2*j+1] : t_age[k][2*j];
        t_idx[k+1][j] = pick_hi ? t_idx[k][2*j+1] : t_idx[k][2*j];
        t_vld[k+1][j] = t_vld[k][2*j] || t_vld[k][2*j+1];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cur_r.kind == CMD_ACCESS || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        row_vld_r[cur_r.set_addr] <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_req;
    end
    if (load_out) begin
      victim_r <= t_idx[LEVELS][0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign victim_way = victim_r;

  a_write_only_access: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EXEC) && (cur_r.kind == CMD_ACCESS))
    else $error("row write outside an access request");

  a_pop_starts_exec: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == S_EXEC))
    else $error("popped request did not reach execute");

  a_query_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r && (state_r == S_IDLE))
    else $error("query result not presented");

  a_access_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && (cur_r.kind == CMD_ACCESS)) |-> !load_out)
    else $error("access request produced a result");

endmodule

// ----- rtl/lru_age_counter_replacement_core.sv -----
// Each request passes through two back-end states, one that reads the row from the age
// memory and one that does the update write or the victim search; the back end takes no
// new request until it is done with the last, and a query waits while the output stalls.
// A two-entry queue lets the input keep accepting while the back end works or waits.
// Synchronous active-low reset clears the per-set valid bits, which makes every age
// read as zero, and restores the way count to sixteen; no clearing pass is needed.
module lru_age_counter_replacement_core import lruac_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [CFG_BITS-1:0] cfg_wr_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [15:0]         in_tdata,   // set_addr [7:0], way [11:8], zero [15:12]
  input  logic [0:0]          in_tuser,   // command [0]
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata   // victim_way [3:0], zero [7:4]
);

  logic                push;
  req_t                push_req;
  logic                pop;
  req_t                pop_req;
  logic                q_full;
  logic                q_empty;
  logic [WAY_BITS-1:0] victim_way;

  lruac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .q_full      (q_full),
    .push        (push),
    .push_req    (push_req)
  );

  lruac_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .pop      (pop),
    .pop_req  (pop_req),
    .full     (q_full),
    .empty    (q_empty)
  );

  lruac_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_req      (pop_req),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .victim_way (victim_way)
  );

  assign in_tready = !q_full;
  assign out_tdata = {(8 - WAY_BITS)'(0), victim_way};

endmodule

// ----- sim/lru_age_counter_replacement_core_test.sv -----
`timescale 1ns / 1ps
module lru_age_counter_replacement_core_test;
  import lruac_pkg::*;

  typedef struct packed {
    logic                kind;
    logic [SET_BITS-1:0] set_addr;
    logic [WAY_BITS-1:0] way;
  } cache_req_t;

  localparam logic [AGE_WIDTH-1:0] AGE_MAX = '1;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_REQUESTS = 255;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [CFG_BITS-1:0] cfg_wr_data = '0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata = '0;
  logic [0:0]          in_tuser = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [7:0]          out_tdata;

  cache_req_t           pending_requests[$];
  logic [WAY_BITS-1:0]  expected_victims[$];
  logic [AGE_WIDTH-1:0] way_age [SETS][MAX_WAYS];
  logic [CFG_BITS-1:0]  ways_setting = WAYS_RESET;
  cache_req_t           offered_req;
  bit                   offered_taken = 1'b0;
  int unsigned          requests_queued = 0;
  int unsigned          requests_accepted = 0;
  int unsigned          cycle_count = 0;
  int unsigned          error_count = 0;
  bit                   random_phase = 1'b0;
  bit                   ready_hold_done = 1'b0;
  int unsigned          ready_hold_left = 0;

  lru_age_counter_replacement_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_way_count();
    int n;
    n = int'(ways_setting);
    if (n == 0) n = 1;
    if (n > MAX_WAYS) n = MAX_WAYS;
    return n;
  endfunction

  // In the last quarter of each repeating window of the cycle count, neither side idles.
  function automatic bit idle_now();
    if ((cycle_count % 4000) >= 3000) return 1'b0;
    return $urandom_range(0, 99) < 16;
  endfunction

  task automatic track_request(input cache_req_t req);
    int                   n;
    logic [WAY_BITS-1:0]  victim;
    logic [AGE_WIDTH-1:0] oldest;
    n = active_way_count();
    if (req.kind == CMD_ACCESS) begin
      for (int i = 0; i < n; i++) begin
        if (i == req.way) begin
          way_age[req.set_addr][i] = '0;
        end else if (way_age[req.set_addr][i] != AGE_MAX) begin
          way_age[req.set_addr][i] = way_age[req.set_addr][i] + AGE_WIDTH'(1);
        end
      end
    end else begin
      victim = '0;
      oldest = way_age[req.set_addr][0];
      for (int i = 1; i < n; i++) begin
        if (way_age[req.set_addr][i] >= oldest) begin
          oldest = way_age[req.set_addr][i];
          victim = WAY_BITS'(i);
        end
      end
      expected_victims.push_back(victim);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_tvalid && in_tready) begin
      track_request(offered_req);
      requests_accepted++;
      offered_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || offered_taken)) begin
      offered_taken = 1'b0;
      if (pending_requests.size() != 0 && !idle_now()) begin
        offered_req = pending_requests.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= offered_req.kind;
        in_tdata <= {4'b0000, offered_req.way, offered_req.set_addr};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // The long hold-off lets the block fill up and push back on requests.
  always @(negedge clk) begin
    if (random_phase && !ready_hold_done) begin
      ready_hold_done = 1'b1;
      ready_hold_left = 400;
    end
    if (ready_hold_left != 0) begin
      ready_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !idle_now();
    end
  end

  always @(posedge clk) begin
    logic [WAY_BITS-1:0] expected_way;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_victims.size() == 0) begin
        error_count++;
        $display("%0t: victim not expected, expected none, actual %0d", $time, out_tdata);
      end else begin
        expected_way = expected_victims.pop_front();
        if (out_tdata !== {4'b0000, expected_way}) begin
          error_count++;
          $display("%0t: victim_way mismatch, expected %0d, actual %0d",
                   $time, expected_way, out_tdata);
        end
      end
    end
  end

  task automatic queue_request(input logic kind, input int set_addr, input int way);
    cache_req_t req;
    req.kind = kind;
    req.set_addr = SET_BITS'(set_addr);
    req.way = WAY_BITS'(way);
    pending_requests.push_back(req);
    requests_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (requests_accepted != requests_queued || expected_victims.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ways(input logic [CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    ways_setting = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Most requests go to a few hot sets so that ages build up between queries.
  task automatic queue_random_requests(input int count);
    int n;
    int hot_base;
    int set_sel;
    int way_sel;
    n = active_way_count();
    hot_base = $urandom_range(0, SETS - 1);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8) set_sel = (hot_base + $urandom_range(0, 3)) % SETS;
      else set_sel = $urandom_range(0, SETS - 1);
      if ($urandom_range(0, 99) < 85) way_sel = $urandom_range(0, n - 1);
      else way_sel = $urandom_range(0, MAX_WAYS - 1);
      queue_request(($urandom_range(0, 9) < 3) ? CMD_QUERY : CMD_ACCESS, set_sel, way_sel);
    end
  endtask

  initial begin
    logic [CFG_BITS-1:0] phase_ways [6];
    foreach (way_age[s, w]) way_age[s][w] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_request(CMD_QUERY, 0, 0);
    queue_request(CMD_ACCESS, 0, 15);
    queue_request(CMD_QUERY, 0, 0);
    queue_request(CMD_ACCESS, 255, 0);
    queue_request(CMD_ACCESS, 255, 5);
    queue_request(CMD_QUERY, 255, 0);
    queue_request(CMD_ACCESS, 170, 10);
    queue_request(CMD_QUERY, 85, 15);
    wait_idle();

    write_ways(5'd1);
    queue_request(CMD_ACCESS, 0, 0);
    queue_request(CMD_ACCESS, 0, 3);
    queue_request(CMD_QUERY, 0, 0);
    wait_idle();

    write_ways(5'd0);
    queue_request(CMD_ACCESS, 1, 0);
    queue_request(CMD_ACCESS, 1, 9);
    queue_request(CMD_QUERY, 1, 0);
    wait_idle();

    write_ways(5'd31);
    queue_request(CMD_QUERY, 0, 0);
    queue_request(CMD_QUERY, 255, 0);
    wait_idle();

    // Two ways in use: accesses to a way outside the way count age both
    // counters of the set without zeroing either of them.
    write_ways(5'd2);
    queue_request(CMD_ACCESS, 2, 0);
    repeat (8) queue_request(CMD_ACCESS, 2, 15);
    queue_request(CMD_QUERY, 2, 0);
    queue_request(CMD_ACCESS, 2, 1);
    queue_request(CMD_QUERY, 2, 0);
    wait_idle();

    phase_ways[0] = 5'd3;
    phase_ways[1] = 5'd8;
    phase_ways[2] = 5'd16;
    phase_ways[3] = 5'd17;
    phase_ways[4] = 5'd1;
    phase_ways[5] = CFG_BITS'($urandom_range(0, 31));
    random_phase = 1'b1;
    foreach (phase_ways[p]) begin
      write_ways(phase_ways[p]);
      queue_random_requests(PHASE_REQUESTS);
      wait_idle();
    end

    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
